>>> rtl/core/cre_pkg.sv
`timescale 1ns / 1ps
// cre_pkg: shared constants and the queue word type for the Catmull-Rom chain evaluator.
// No dependencies.
package cre_pkg;

	localparam int COORD_BITS     = 32;
	localparam int TIME_FRAC_BITS = 16;
	localparam int TIME_BITS      = 24;
	localparam int SEG_BITS       = TIME_BITS - TIME_FRAC_BITS;
	localparam int IDX_BITS       = 8;
	localparam int CFG_BITS       = 8;
	localparam int U_BITS         = TIME_FRAC_BITS + 1;
	localparam int DEF_MAX_POINTS = 256;
	localparam int QUEUE_DEPTH    = 4;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EVAL  = 1'b1;

	// one queued word: either a table write or a classified evaluation
	typedef struct packed {
		logic                  is_write;
		logic [IDX_BITS-1:0]   idx;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [COORD_BITS-1:0] z;
		logic [SEG_BITS-1:0]   seg;
		logic [U_BITS-1:0]     u;
		logic                  clamped;
		logic                  no_segs;
	} cre_item_t;

endpackage

>>> rtl/core/cre_front.sv
`timescale 1ns / 1ps
// cre_front: segment count register and classification of incoming words.
// Depends on cre_pkg.
module cre_front import cre_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_BITS-1:0]   cfg_wdata,
	input  logic                  op,
	input  logic [IDX_BITS-1:0]   point_index,
	input  logic [COORD_BITS-1:0] x_in,
	input  logic [COORD_BITS-1:0] y_in,
	input  logic [COORD_BITS-1:0] z_in,
	input  logic [TIME_BITS-1:0]  eval_time,
	output cre_item_t             item
);

	logic [CFG_BITS-1:0] num_segs_q;
	logic [SEG_BITS-1:0] seg_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_segs_q <= '0;
		end else if (cfg_we) begin
			num_segs_q <= cfg_wdata;
		end
	end

	assign seg_raw = eval_time[TIME_BITS-1:TIME_FRAC_BITS];

	always_comb begin
		item          = '0;
		item.is_write = (op == OP_WRITE);
		item.idx      = point_index;
		item.x        = x_in;
		item.y        = y_in;
		item.z        = z_in;
		item.no_segs  = (num_segs_q == '0);
		// past the last segment: evaluate the last one at t = 1
		if (CFG_BITS'(seg_raw) >= num_segs_q) begin
			item.seg     = SEG_BITS'(num_segs_q - CFG_BITS'(1));
			item.u       = U_BITS'(1) << TIME_FRAC_BITS;
			item.clamped = !item.no_segs;
		end else begin
			item.seg     = seg_raw;
			item.u       = {1'b0, eval_time[TIME_FRAC_BITS-1:0]};
			item.clamped = 1'b0;
		end
	end

endmodule

>>> rtl/core/cre_queue.sv
`timescale 1ns / 1ps
// cre_queue: short FIFO between the classifier and the evaluation pipeline.
// Depends on cre_pkg.
module cre_queue import cre_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cre_item_t push_word,
	input  logic      pop,
	output cre_item_t pop_word,
	output logic      full,
	output logic      empty
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	cre_item_t       buf_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     count_q;

	assign full     = (count_q == (PW+1)'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_word = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PW'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + PW'(1);
			if (push && !pop)      count_q <= count_q + (PW+1)'(1);
			else if (pop && !push) count_q <= count_q - (PW+1)'(1);
		end
	end

endmodule

>>> rtl/core/cre_back.sv
`timescale 1ns / 1ps
// cre_back: point table (four read copies) and the Horner evaluation pipeline.
// Depends on cre_pkg.
module cre_back import cre_pkg::*; #(
	parameter int MAX_POINTS = DEF_MAX_POINTS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  cre_item_t             q_word,
	output logic                  q_pop,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [COORD_BITS-1:0] x_out,
	output logic [COORD_BITS-1:0] y_out,
	output logic [COORD_BITS-1:0] z_out,
	output logic                  clamped,
	output logic                  no_segments
);

	localparam int CW  = COORD_BITS;
	localparam int TF  = TIME_FRAC_BITS;
	localparam int AIW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int XW  = SEG_BITS + 1;
	localparam int AW  = CW + 6;
	localparam int PW  = AW + U_BITS + 1;
	localparam logic signed [PW-1:0] RND  = PW'(1) << (TF - 1);
	localparam logic signed [AW-1:0] SMAX = AW'((64'd1 << (CW - 1)) - 64'd1);
	localparam logic signed [AW-1:0] SMIN = -SMAX - AW'(1);

	typedef struct packed {
		logic           clamped;
		logic           no_segs;
		logic [U_BITS-1:0] u;
	} side_t;

	logic adv;
	logic pop_eval;

	// stage valids and side-band
	logic  v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	side_t sd_s1, sd_s2, sd_s3, sd_s4, sd_s5, sd_s6, sd_s7, sd_s8;
	logic [3:0] inr_s1;

	logic [3*CW-1:0] mem0 [MAX_POINTS];
	logic [3*CW-1:0] mem1 [MAX_POINTS];
	logic [3*CW-1:0] mem2 [MAX_POINTS];
	logic [3*CW-1:0] mem3 [MAX_POINTS];
	logic [3*CW-1:0] rd_s1 [4];

	logic [XW-1:0]  ix [4];
	logic [3:0]     inr;
	logic           wr_en;
	logic [AIW-1:0] wr_addr;

	logic signed [AW-1:0] a0_s2 [3], a1_s2 [3], a2_s2 [3], a3_s2 [3];
	logic signed [PW-1:0] pr_s3 [3];
	logic signed [AW-1:0] a0_s3 [3], a1_s3 [3], a2_s3 [3];
	logic signed [AW-1:0] ac_s4 [3], a0_s4 [3], a1_s4 [3];
	logic signed [PW-1:0] pr_s5 [3];
	logic signed [AW-1:0] a0_s5 [3], a1_s5 [3];
	logic signed [AW-1:0] ac_s6 [3], a0_s6 [3];
	logic signed [PW-1:0] pr_s7 [3];
	logic signed [AW-1:0] a0_s7 [3];
	logic signed [AW-1:0] ac_s8 [3];

	logic signed [AW-1:0] co0 [3], co1 [3], co2 [3], co3 [3];
	logic signed [AW-1:0] fin [3];
	logic [CW-1:0]        res [3];

	logic                 res_valid_q;
	logic [CW-1:0]        res_q [3];
	logic                 clamped_q, no_segs_q;

	function automatic logic signed [PW-1:0] rnd_shift(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] t;
		t = (p + RND) >>> TF;
		return t;
	endfunction

	assign adv      = !res_valid_q || !result_stall;
	assign q_pop    = adv && !q_empty;
	assign pop_eval = q_pop && !q_word.is_write;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			ix[k]  = XW'(q_word.seg) + XW'(k);
			inr[k] = int'(ix[k]) < MAX_POINTS;
		end
		wr_en   = q_pop && q_word.is_write && (int'(q_word.idx) < MAX_POINTS);
		wr_addr = AIW'(q_word.idx);
	end

	// table copies share each write; each serves one of the four points
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem0[wr_addr] <= {q_word.z, q_word.y, q_word.x};
			mem1[wr_addr] <= {q_word.z, q_word.y, q_word.x};
			mem2[wr_addr] <= {q_word.z, q_word.y, q_word.x};
			mem3[wr_addr] <= {q_word.z, q_word.y, q_word.x};
		end
		if (adv) begin
			rd_s1[0] <= mem0[AIW'(ix[0])];
			rd_s1[1] <= mem1[AIW'(ix[1])];
			rd_s1[2] <= mem2[AIW'(ix[2])];
			rd_s1[3] <= mem3[AIW'(ix[3])];
		end
	end

	// coefficients; points past the table read as zero
	always_comb begin
		logic signed [AW-1:0] p [4];
		for (int a = 0; a < 3; a++) begin
			for (int k = 0; k < 4; k++) begin
				p[k] = inr_s1[k] ? AW'($signed(rd_s1[k][a*CW +: CW])) : '0;
			end
			co0[a] = p[1] <<< 1;
			co1[a] = p[2] - p[0];
			co2[a] = (p[0] <<< 1) - (p[1] <<< 2) - p[1] + (p[2] <<< 2) - p[3];
			co3[a] = p[3] - p[0] + (p[1] <<< 1) + p[1] - (p[2] <<< 1) - p[2];
		end
	end

	always_comb begin
		logic signed [AW-1:0] r;
		for (int a = 0; a < 3; a++) begin
			fin[a] = (ac_s8[a] + AW'(1)) >>> 1;
			r = fin[a];
			if (r > SMAX) r = SMAX;
			if (r < SMIN) r = SMIN;
			res[a] = sd_s8.no_segs ? '0 : r[CW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s1  <= '{clamped: q_word.clamped, no_segs: q_word.no_segs, u: q_word.u};
			inr_s1 <= inr;
			sd_s2 <= sd_s1;
			sd_s3 <= sd_s2;
			sd_s4 <= sd_s3;
			sd_s5 <= sd_s4;
			sd_s6 <= sd_s5;
			sd_s7 <= sd_s6;
			sd_s8 <= sd_s7;
			for (int a = 0; a < 3; a++) begin
				a0_s2[a] <= co0[a];
				a1_s2[a] <= co1[a];
				a2_s2[a] <= co2[a];
				a3_s2[a] <= co3[a];
				pr_s3[a] <= a3_s2[a] * $signed({1'b0, sd_s2.u});
				a0_s3[a] <= a0_s2[a];
				a1_s3[a] <= a1_s2[a];
				a2_s3[a] <= a2_s2[a];
				ac_s4[a] <= AW'(rnd_shift(pr_s3[a])) + a2_s3[a];
				a0_s4[a] <= a0_s3[a];
				a1_s4[a] <= a1_s3[a];
				pr_s5[a] <= ac_s4[a] * $signed({1'b0, sd_s4.u});
				a0_s5[a] <= a0_s4[a];
				a1_s5[a] <= a1_s4[a];
				ac_s6[a] <= AW'(rnd_shift(pr_s5[a])) + a1_s5[a];
				a0_s6[a] <= a0_s5[a];
				pr_s7[a] <= ac_s6[a] * $signed({1'b0, sd_s6.u});
				a0_s7[a] <= a0_s6[a];
				ac_s8[a] <= AW'(rnd_shift(pr_s7[a])) + a0_s7[a];
			end
		end
		if (adv && v_s8) begin
			res_q[0]  <= res[0];
			res_q[1]  <= res[1];
			res_q[2]  <= res[2];
			clamped_q <= sd_s8.clamped;
			no_segs_q <= sd_s8.no_segs;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= pop_eval;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			res_valid_q <= v_s8;
		end
	end

	assign result_valid = res_valid_q;
	assign x_out        = res_q[0];
	assign y_out        = res_q[1];
	assign z_out        = res_q[2];
	assign clamped      = clamped_q;
	assign no_segments  = no_segs_q;

endmodule

>>> rtl/core/catmull_rom_chain_eval.sv
`timescale 1ns / 1ps
// Uniform Catmull-Rom chain evaluator, top level.
// Depends on cre_pkg, cre_front, cre_queue, cre_back.
//
// Takes one word per clock while item_stall is low: op 0 writes a control point into the
// table, op 1 evaluates the chain at eval_time (Q8.16) and gives one result word; writes
// give none. Words are classified on entry, pass a four-deep queue, then run a nine-stage
// pipeline: a table read (four copies of the table, one per segment point), coefficient
// build, and three multiply / round-add steps of Horner's rule, then the halving and
// saturation into the output register. The sustained rate is one word per cycle when the
// output is not stalled. item_stall rises only when the queue is full. The table is not
// cleared at reset; entries must be written before a segment that uses them.
module catmull_rom_chain_eval import cre_pkg::*; #(
	parameter int MAX_POINTS = DEF_MAX_POINTS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_BITS-1:0]   cfg_wdata,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic                  op,
	input  logic [IDX_BITS-1:0]   point_index,
	input  logic [COORD_BITS-1:0] x_in,
	input  logic [COORD_BITS-1:0] y_in,
	input  logic [COORD_BITS-1:0] z_in,
	input  logic [TIME_BITS-1:0]  eval_time,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [COORD_BITS-1:0] x_out,
	output logic [COORD_BITS-1:0] y_out,
	output logic [COORD_BITS-1:0] z_out,
	output logic                  clamped,
	output logic                  no_segments
);

	cre_item_t in_word;
	cre_item_t q_word;
	logic      q_full, q_empty, q_pop;

	assign item_stall = q_full;

	cre_front u_front (
		.clk, .arst_n, .cfg_we, .cfg_wdata,
		.op, .point_index, .x_in, .y_in, .z_in, .eval_time,
		.item (in_word)
	);

	cre_queue u_queue (
		.clk, .arst_n,
		.push      (item_valid && !q_full),
		.push_word (in_word),
		.pop       (q_pop),
		.pop_word  (q_word),
		.full      (q_full),
		.empty     (q_empty)
	);

	cre_back #(.MAX_POINTS(MAX_POINTS)) u_back (
		.clk, .arst_n,
		.q_empty, .q_word, .q_pop,
		.result_valid, .result_stall,
		.x_out, .y_out, .z_out, .clamped, .no_segments
	);

endmodule

>>> tb/sv/tb_catmull_rom_chain_eval.sv
`timescale 1ns / 1ps
// Self-checking testbench for catmull_rom_chain_eval: directed table, then random phases.
// Depends on cre_pkg and the catmull_rom_chain_eval RTL.
module tb_catmull_rom_chain_eval;
	import cre_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int HOLD_CYCLES    = 300;
	localparam longint UNIT_T     = 64'sd1 <<< TIME_FRAC_BITS;
	localparam longint COORD_MAX  = (64'sd1 <<< (COORD_BITS - 1)) - 1;
	localparam longint COORD_MIN  = -(64'sd1 <<< (COORD_BITS - 1));

	typedef struct {
		logic                  op;
		logic [IDX_BITS-1:0]   idx;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [COORD_BITS-1:0] z;
		logic [TIME_BITS-1:0]  t;
	} word_t;

	typedef struct {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [COORD_BITS-1:0] z;
		logic                  clamped;
		logic                  no_segs;
	} point_res_t;

	typedef struct {
		word_t      w;
		bit         set_cfg;
		int         cfg_val;
		bit         typed;
		point_res_t exp_res;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_BITS-1:0]   cfg_wdata = '0;
	logic                  item_valid = 1'b0;
	logic                  item_stall;
	logic                  op = OP_WRITE;
	logic [IDX_BITS-1:0]   point_index = '0;
	logic [COORD_BITS-1:0] x_in = '0;
	logic [COORD_BITS-1:0] y_in = '0;
	logic [COORD_BITS-1:0] z_in = '0;
	logic [TIME_BITS-1:0]  eval_time = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	logic [COORD_BITS-1:0] x_out;
	logic [COORD_BITS-1:0] y_out;
	logic [COORD_BITS-1:0] z_out;
	logic                  clamped;
	logic                  no_segments;

	catmull_rom_chain_eval u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.item_valid(item_valid), .item_stall(item_stall), .op(op),
		.point_index(point_index), .x_in(x_in), .y_in(y_in), .z_in(z_in),
		.eval_time(eval_time), .result_valid(result_valid), .result_stall(result_stall),
		.x_out(x_out), .y_out(y_out), .z_out(z_out), .clamped(clamped),
		.no_segments(no_segments)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	longint     ctrl_pts [DEF_MAX_POINTS][3];
	int         seg_count = 0;
	point_res_t pending_points [$];
	int         err_count = 0;
	bit         hold_req = 1'b0;
	bit         gaps_on = 1'b1;
	int         burst_left = 0;

	// round(a * u / 2^F), ties up
	function automatic longint frac_scale(longint a, longint u);
		longint h, l, lo;
		h = a >>> TIME_FRAC_BITS;
		l = a - (h <<< TIME_FRAC_BITS);
		lo = (l * u + (64'sd1 <<< (TIME_FRAC_BITS - 1))) >>> TIME_FRAC_BITS;
		return h * u + lo;
	endfunction

	function automatic logic [COORD_BITS-1:0] spline_axis(int seg, longint u, int ax);
		longint p0, p1, p2, p3, acc;
		p0 = ctrl_pts[seg][ax];
		p1 = ctrl_pts[seg+1][ax];
		p2 = ctrl_pts[seg+2][ax];
		p3 = ctrl_pts[seg+3][ax];
		acc = -p0 + 3 * p1 - 3 * p2 + p3;
		acc = frac_scale(acc, u) + (2 * p0 - 5 * p1 + 4 * p2 - p3);
		acc = frac_scale(acc, u) + (p2 - p0);
		acc = frac_scale(acc, u) + 2 * p1;
		acc = (acc + 1) >>> 1;
		if (acc < COORD_MIN) acc = COORD_MIN;
		if (acc > COORD_MAX) acc = COORD_MAX;
		return acc[COORD_BITS-1:0];
	endfunction

	function automatic point_res_t spline_point(logic [TIME_BITS-1:0] t);
		point_res_t r;
		int seg;
		longint u;
		r = '{default: '0};
		if (seg_count == 0) begin
			r.no_segs = 1'b1;
			return r;
		end
		seg = int'(t[TIME_BITS-1:TIME_FRAC_BITS]);
		u = longint'(t[TIME_FRAC_BITS-1:0]);
		if (seg >= seg_count) begin
			seg = seg_count - 1;
			u = UNIT_T;
			r.clamped = 1'b1;
		end
		r.x = spline_axis(seg, u, 0);
		r.y = spline_axis(seg, u, 1);
		r.z = spline_axis(seg, u, 2);
		return r;
	endfunction

	// Drives one word until an edge takes it, updates table or expectations, may pause after.
	task automatic send_word(word_t w, bit typed, point_res_t exp_res);
		item_valid  <= 1'b1;
		op          <= w.op;
		point_index <= w.idx;
		x_in        <= w.x;
		y_in        <= w.y;
		z_in        <= w.z;
		eval_time   <= w.t;
		do @(posedge clk); while (item_stall);
		if (w.op == OP_WRITE) begin
			ctrl_pts[w.idx][0] = longint'(signed'(w.x));
			ctrl_pts[w.idx][1] = longint'(signed'(w.y));
			ctrl_pts[w.idx][2] = longint'(signed'(w.z));
		end else begin
			pending_points.push_back(typed ? exp_res : spline_point(w.t));
		end
		if (gaps_on) begin
			if (burst_left == 0) begin
				item_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				burst_left = $urandom_range(0, 25);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic set_segments(int v);
		item_valid <= 1'b0;
		while (pending_points.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v[CFG_BITS-1:0];
		@(posedge clk);
		cfg_we    <= 1'b0;
		seg_count = v;
	endtask

	function automatic logic [COORD_BITS-1:0] rand_coord();
		logic [31:0] r;
		r = $urandom;
		if ($urandom_range(0, 1)) return r;
		return {{(COORD_BITS-21){r[20]}}, r[20:0]};
	endfunction

	function automatic word_t rand_word(int eval_pct);
		word_t w;
		int seg;
		w.op  = ($urandom_range(0, 99) < eval_pct) ? OP_EVAL : OP_WRITE;
		w.idx = IDX_BITS'($urandom_range(0, DEF_MAX_POINTS - 1));
		w.x   = rand_coord();
		w.y   = rand_coord();
		w.z   = rand_coord();
		seg   = (seg_count > 0) ? $urandom_range(0, seg_count - 1) : $urandom_range(0, 255);
		w.t   = {seg[SEG_BITS-1:0], TIME_FRAC_BITS'($urandom)};
		case ($urandom_range(0, 9))
			0: w.t[TIME_FRAC_BITS-1:0] = '0;
			1: w.t[TIME_BITS-1:TIME_FRAC_BITS] = SEG_BITS'($urandom_range(seg_count, 255));
			2: w.t = '1;
			default: ;
		endcase
		return w;
	endfunction

	task automatic report_mismatch(string what, logic [COORD_BITS-1:0] want,
			logic [COORD_BITS-1:0] got);
		$display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
		err_count++;
	endtask

	// result checker
	always @(posedge clk) begin
		point_res_t e;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_points.size() == 0) begin
				report_mismatch("unexpected word", '0, x_out);
			end else begin
				e = pending_points.pop_front();
				if (x_out !== e.x) report_mismatch("x_out", e.x, x_out);
				if (y_out !== e.y) report_mismatch("y_out", e.y, y_out);
				if (z_out !== e.z) report_mismatch("z_out", e.z, z_out);
				if (clamped !== e.clamped) report_mismatch("clamped", e.clamped, clamped);
				if (no_segments !== e.no_segs)
					report_mismatch("no_segments", e.no_segs, no_segments);
			end
		end
	end

	// receiver stall pattern, with a long hold-off on request
	int hold_cnt = 0;
	int pat_left = 0;
	int stall_pct = 0;
	always @(posedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt--;
			result_stall <= 1'b1;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_cnt = HOLD_CYCLES;
			result_stall <= 1'b1;
		end else begin
			if (pat_left == 0) begin
				pat_left = $urandom_range(20, 150);
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 30;
					default: stall_pct = 75;
				endcase
			end
			pat_left--;
			result_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// watchdog: cycles with no word moving on either side
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) || cfg_we)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	dir_row_t dir_rows [$];

	function automatic dir_row_t mk_row(logic o, int idx, logic [31:0] x, logic [31:0] y,
			logic [31:0] z, logic [23:0] t, bit setc, int cv, bit typed,
			logic [31:0] ex, logic [31:0] ey, logic [31:0] ez, logic ec, logic en);
		dir_row_t r;
		r.w = '{op: o, idx: idx[IDX_BITS-1:0], x: x, y: y, z: z, t: t};
		r.set_cfg = setc;
		r.cfg_val = cv;
		r.typed = typed;
		r.exp_res = '{x: ex, y: ey, z: ez, clamped: ec, no_segs: en};
		return r;
	endfunction

	initial begin
		int phase_cfg [6];
		point_res_t none;
		none = '{default: '0};

		// eval before any segment exists
		dir_rows.push_back(mk_row(OP_EVAL, 0, 0, 0, 0, 24'h000000, 0, 0, 1, 0, 0, 0, 0, 1));
		for (int i = 0; i < 4; i++)
			dir_rows.push_back(mk_row(OP_WRITE, i, 32'h7FFFFFFF, 32'h80000000, 0, 0,
				0, 0, 0, 0, 0, 0, 0, 0));
		// flat chain gives the point itself, at either end and when clamped
		dir_rows.push_back(mk_row(OP_EVAL, 0, 0, 0, 0, 24'h000000, 1, 1, 1,
			32'h7FFFFFFF, 32'h80000000, 0, 0, 0));
		dir_rows.push_back(mk_row(OP_EVAL, 0, 0, 0, 0, 24'h008000, 0, 0, 1,
			32'h7FFFFFFF, 32'h80000000, 0, 0, 0));
		dir_rows.push_back(mk_row(OP_EVAL, 0, 0, 0, 0, 24'hFFFFFF, 0, 0, 1,
			32'h7FFFFFFF, 32'h80000000, 0, 1, 0));
		dir_rows.push_back(mk_row(OP_EVAL, 0, 0, 0, 0, 24'h010000, 0, 0, 1,
			32'h7FFFFFFF, 32'h80000000, 0, 1, 0));
		// overshooting chain drives the output into saturation
		dir_rows.push_back(mk_row(OP_WRITE, 0, 32'h80000000, 32'h7FFFFFFF, 32'h00010000, 0,
			0, 0, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(OP_WRITE, 1, 32'h7FFFFFFF, 32'h80000000, 32'hFFFF0000, 0,
			0, 0, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(OP_WRITE, 2, 32'h7FFFFFFF, 32'h80000000, 32'h00030000, 0,
			0, 0, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(OP_WRITE, 3, 32'h80000000, 32'h7FFFFFFF, 32'h00000001, 0,
			0, 0, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(OP_EVAL, 0, 0, 0, 0, 24'h008000, 0, 0, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(OP_EVAL, 0, 0, 0, 0, 24'h00FFFF, 0, 0, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(OP_EVAL, 0, 0, 0, 0, 24'h000001, 0, 0, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(OP_WRITE, 255, 32'h00000001, 32'hFFFFFFFF, 32'h12345678, 0,
			0, 0, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(OP_EVAL, 0, 0, 0, 0, 24'h123456, 1, 0, 1, 0, 0, 0, 0, 1));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].set_cfg) set_segments(dir_rows[i].cfg_val);
			send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].exp_res);
		end

		// load every table entry so any segment count is safe
		for (int i = 0; i < DEF_MAX_POINTS; i++) begin
			word_t w;
			w = rand_word(0);
			w.idx = IDX_BITS'(i);
			send_word(w, 0, none);
		end

		phase_cfg = '{253, 1, 0, $urandom_range(1, 253), 253, $urandom_range(2, 10)};
		foreach (phase_cfg[p]) begin
			set_segments(phase_cfg[p]);
			if (p == 4) begin
				// receiver holds off while words keep coming
				hold_req = 1'b1;
				gaps_on = 1'b0;
			end
			repeat (60) send_word(rand_word(70), 0, none);
			gaps_on = 1'b1;
		end

		item_valid <= 1'b0;
		while (pending_points.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0 && pending_points.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

>>> files.f
rtl/core/cre_pkg.sv
rtl/core/cre_front.sv
rtl/core/cre_queue.sv
rtl/core/cre_back.sv
rtl/core/catmull_rom_chain_eval.sv
tb/sv/tb_catmull_rom_chain_eval.sv
